FILE: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// shared constants, state codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int FRAME_CAPACITY = 19;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 5;
  localparam int IDX_W  = $clog2(FRAME_CAPACITY);
  localparam int CNT_W  = $clog2(FRAME_CAPACITY + 1);

  localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
  localparam logic [BYTE_W-1:0] ESC_XOR   = 8'h20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_IN,
    ST_ESC,
    ST_RD,
    ST_OUT
  } sfr_state_t;

  typedef struct packed {
    logic clear;
    logic store;
    logic esc_xor;
    logic rd;
    logic idx_clr;
    logic idx_inc;
  } sfr_cmd_t;

  typedef struct packed {
    logic is_flag;
    logic is_esc;
    logic empty;
    logic last;
  } sfr_status_t;

endpackage

FILE: rtl/sfr_ram.sv
// ----------------------------------------------------------------------------
// sfr_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/sfr_datapath.sv
// ----------------------------------------------------------------------------
// sfr_datapath
// byte classification, frame store, fill count, overflow mark and read index
// ----------------------------------------------------------------------------
module sfr_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [sfr_pkg::BYTE_W-1:0]  rx_byte,
  input  sfr_pkg::sfr_cmd_t           cmd,
  output sfr_pkg::sfr_status_t        status,
  output logic [sfr_pkg::BYTE_W-1:0]  frame_byte,
  output logic [sfr_pkg::POS_W-1:0]   byte_position,
  output logic                        last_of_frame,
  output logic                        truncated
);

  import sfr_pkg::*;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              full;
  logic              wr_en;
  logic [BYTE_W-1:0] wr_data;
  logic              last;

  assign full    = (count_r == CNT_W'(FRAME_CAPACITY));
  assign wr_en   = cmd.store && !full;
  assign wr_data = cmd.esc_xor ? (rx_byte ^ ESC_XOR) : rx_byte;
  assign last    = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    idx_nxt   = idx_r;
    if (cmd.clear) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (cmd.store) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      idx_r   <= '0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      idx_r   <= idx_nxt;
    end
  end

  sfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRAME_CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(count_r)),
    .wr_data (wr_data),
    .rd_en   (cmd.rd),
    .rd_addr (idx_r),
    .rd_data (frame_byte)
  );

  assign status.is_flag = (rx_byte == FLAG_BYTE);
  assign status.is_esc  = (rx_byte == ESC_BYTE);
  assign status.empty   = (count_r == '0);
  assign status.last    = last;

  assign byte_position = POS_W'(idx_r);
  assign last_of_frame = last;
  assign truncated     = ovf_r;

endmodule

FILE: rtl/sfr_ctrl.sv
// ----------------------------------------------------------------------------
// sfr_ctrl
// receive phase and frame playback state machine
// ----------------------------------------------------------------------------
module sfr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  sfr_pkg::sfr_status_t  status,
  output sfr_pkg::sfr_cmd_t     cmd
);

  import sfr_pkg::*;

  sfr_state_t state_r, state_nxt;
  logic       in_acc;

  assign in_stall  = (state_r == ST_RD) || (state_r == ST_OUT);
  assign out_valid = (state_r == ST_OUT);
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && status.is_flag) begin
          cmd.clear = 1'b1;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (in_acc && !status.is_flag) begin
          cmd.store = 1'b1;
          state_nxt = ST_IN;
        end
      end
      ST_IN: begin
        if (in_acc) begin
          priority if (status.is_esc) begin
            state_nxt = ST_ESC;
          end else if (status.is_flag) begin
            cmd.idx_clr = 1'b1;
            state_nxt   = status.empty ? ST_IDLE : ST_RD;
          end else begin
            cmd.store = 1'b1;
          end
        end
      end
      ST_ESC: begin
        if (in_acc) begin
          cmd.store   = 1'b1;
          cmd.esc_xor = 1'b1;
          state_nxt   = ST_IN;
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (status.last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/stuffed_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_top
// byte-stuffed frame receiver: flag delimited frames with escape unstuffing
// ----------------------------------------------------------------------------
// in_ channel: one raw serial byte per request on in_rx_byte. A data or
//   escape byte is taken as soon as it is offered; the block keeps taking
//   bytes back to back while a frame is being collected.
// out_ channel: on the closing flag the stored frame is replayed, one request
//   per byte, with its position, a last mark on the final byte and a
//   truncated mark when bytes beyond the 19 entry store were dropped.
// playback: after the closing flag is taken, each byte is read from the
//   frame store in a read state and then shown in the output state, since
//   the store read is registered; each further byte is read once the previous one is taken.
// throughput: one input byte per cycle while collecting; the input stays
//   stalled for the whole playback of a frame, including receiver stalls.
// reset: synchronous, active low; returns to waiting for an opening flag,
//   clears the fill count and overflow mark. The store itself is not cleared.
// receiver stall: out_stall holds the current byte and its marks unchanged,
//   and in_stall stays high until the last byte of the run is taken.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sfr_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sfr_pkg::BYTE_W-1:0]  out_frame_byte,
  output logic [sfr_pkg::POS_W-1:0]   out_byte_position,
  output logic                        out_last_of_frame,
  output logic                        out_truncated
);

  import sfr_pkg::*;

  sfr_cmd_t    cmd;
  sfr_status_t status;

  sfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  sfr_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_byte       (in_rx_byte),
    .cmd           (cmd),
    .status        (status),
    .frame_byte    (out_frame_byte),
    .byte_position (out_byte_position),
    .last_of_frame (out_last_of_frame),
    .truncated     (out_truncated)
  );

endmodule

FILE: rtl/sfr_checker.sv
// ----------------------------------------------------------------------------
// sfr_checker
// port level checks of the frame receiver, bound to the top level
// ----------------------------------------------------------------------------
module sfr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [sfr_pkg::BYTE_W-1:0]  in_rx_byte,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [sfr_pkg::BYTE_W-1:0]  out_frame_byte,
  input logic [sfr_pkg::POS_W-1:0]   out_byte_position,
  input logic                        out_last_of_frame,
  input logic                        out_truncated
);

  import sfr_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_rx_byte)))
    else $error("stalled request changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_frame_byte)
      && $stable(out_byte_position) && $stable(out_last_of_frame)
      && $stable(out_truncated)))
    else $error("stalled result changed");

  a_no_input_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken during frame playback");

  a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_of_frame) |=> ##1 (out_valid
      && (out_byte_position == $past(out_byte_position, 2) + POS_W'(1))
      && (out_truncated == $past(out_truncated, 2))))
    else $error("frame run out of order");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_of_frame) |=> (!out_valid && !in_stall))
    else $error("no return to receive after last byte");

endmodule

bind stuffed_frame_receiver_top sfr_checker u_sfr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_rx_byte        (in_rx_byte),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_frame_byte    (out_frame_byte),
  .out_byte_position (out_byte_position),
  .out_last_of_frame (out_last_of_frame),
  .out_truncated     (out_truncated)
);
